// ----- rtl/tdms_pkg.sv -----
// Package for the touch drag to mouse step converter.
// Holds field widths, action codes, step limits and the default coordinate width.
// No dependencies.
package tdms_pkg;

   localparam int TOUCH_BITS       = 9;
   localparam int COORD_BITS_DEF   = 9;
   localparam int STEP_BITS        = 6;
   localparam int THRESH           = 10;
   localparam int STEP_MAX         = 20;

   typedef enum logic [1:0] {
      ACT_PRESS   = 2'd0,
      ACT_DRAG    = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_CLICK   = 2'd3
   } action_type;

   typedef enum logic {
      KIND_MOVE  = 1'b0,
      KIND_CLICK = 1'b1
   } report_kind_type;

endpackage

// ----- rtl/touch_drag_to_mouse_steps.sv -----
// Touch drag to relative mouse step converter, top level; depends on tdms_pkg.
// A click goes through ST_EMIT to the output register; a drag goes through ST_SUMX, ST_SUMY
// and ST_EMIT before its first step. req_ready is high only in ST_IDLE, so a new touch item
// waits until the last is done. A drag gives N <= 52 steps, one step a cycle while rsp_ready is high.
// Reset: synchronous, active high; HID mode on, no stored point, residuals zero.
module touch_drag_to_mouse_steps import tdms_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [TOUCH_BITS-1:0]       req_touch_x,
   input  logic [TOUCH_BITS-1:0]       req_touch_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_report_kind,
   output logic signed [STEP_BITS-1:0] rsp_move_x,
   output logic signed [STEP_BITS-1:0] rsp_move_y,
   output logic                        rsp_last_of_run
);

   localparam int RES_BITS = COORD_BITS + 3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUMX = 4'b0010,
      ST_SUMY = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   function automatic logic signed [STEP_BITS-1:0] clamp_step(
      input logic signed [RES_BITS-1:0] v);
      logic signed [RES_BITS-1:0] lim;
      lim = RES_BITS'(STEP_MAX);
      if (v > lim) begin
         return STEP_BITS'(STEP_MAX);
      end else if (v < -lim) begin
         return STEP_BITS'(-STEP_MAX);
      end
      return v[STEP_BITS-1:0];
   endfunction

   function automatic logic over_thresh(input logic signed [RES_BITS-1:0] v);
      logic signed [RES_BITS-1:0] thr;
      thr = RES_BITS'(THRESH);
      return (v >= thr) || (v <= -thr);
   endfunction

   state_type                   state_ff, state_in;
   logic                        hid_ff, hid_in;
   logic                        point_valid_ff, point_valid_in;
   logic [COORD_BITS-1:0]       prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [COORD_BITS-1:0]       cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [RES_BITS-1:0]  res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                        click_ff, click_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        kind_ff, kind_in;
   logic signed [STEP_BITS-1:0] mx_ff, mx_in, my_ff, my_in;
   logic                        last_ff, last_in;

   logic                        accept;
   logic                        slot_free;
   action_type                  act;
   logic [COORD_BITS-1:0]       in_x, in_y;

   // shared accumulate unit: res + 2 * (cur - prev)
   logic [COORD_BITS-1:0]       op_cur, op_prev;
   logic signed [RES_BITS-1:0]  op_res;
   logic signed [COORD_BITS:0]  diff;
   logic signed [RES_BITS-1:0]  acc_sum;

   logic signed [STEP_BITS-1:0] step_x, step_y;
   logic signed [RES_BITS-1:0]  left_x, left_y;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign act       = action_type'(req_action);
   assign in_x      = req_touch_x[COORD_BITS-1:0];
   assign in_y      = req_touch_y[COORD_BITS-1:0];

   assign op_cur  = (state_ff == ST_SUMX) ? cur_x_ff  : cur_y_ff;
   assign op_prev = (state_ff == ST_SUMX) ? prev_x_ff : prev_y_ff;
   assign op_res  = (state_ff == ST_SUMX) ? res_x_ff  : res_y_ff;
   assign diff    = $signed({1'b0, op_cur}) - $signed({1'b0, op_prev});
   assign acc_sum = op_res + (RES_BITS'(diff) <<< 1);

   assign step_x = clamp_step(res_x_ff);
   assign step_y = clamp_step(res_y_ff);
   assign left_x = res_x_ff - RES_BITS'(step_x);
   assign left_y = res_y_ff - RES_BITS'(step_y);

   always_comb begin
      state_in       = state_ff;
      hid_in         = hid_ff;
      point_valid_in = point_valid_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      click_in       = click_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      kind_in        = kind_ff;
      mx_in          = mx_ff;
      my_in          = my_ff;
      last_in        = last_ff;

      if (csr_wr_en) begin
         hid_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && hid_ff) begin
               unique case (act)
                  ACT_PRESS: begin
                     prev_x_in      = in_x;
                     prev_y_in      = in_y;
                     point_valid_in = 1'b1;
                     res_x_in       = '0;
                     res_y_in       = '0;
                  end
                  ACT_DRAG: begin
                     if (!point_valid_ff) begin
                        prev_x_in      = in_x;
                        prev_y_in      = in_y;
                        point_valid_in = 1'b1;
                     end else begin
                        cur_x_in = in_x;
                        cur_y_in = in_y;
                        click_in = 1'b0;
                        state_in = ST_SUMX;
                     end
                  end
                  ACT_RELEASE: begin
                     point_valid_in = 1'b0;
                     prev_x_in      = '0;
                     prev_y_in      = '0;
                     res_x_in       = '0;
                     res_y_in       = '0;
                  end
                  ACT_CLICK: begin
                     click_in = 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_SUMX: begin
            res_x_in  = acc_sum;
            prev_x_in = cur_x_ff;
            state_in  = ST_SUMY;
         end
         ST_SUMY: begin
            res_y_in  = acc_sum;
            prev_y_in = cur_y_ff;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (click_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_CLICK;
                  mx_in        = '0;
                  my_in        = '0;
                  last_in      = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (!over_thresh(res_x_ff) && !over_thresh(res_y_ff)) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_MOVE;
               mx_in        = step_x;
               my_in        = step_y;
               res_x_in     = left_x;
               res_y_in     = left_y;
               last_in      = !(over_thresh(left_x) || over_thresh(left_y));
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hid_ff         <= 1'b1;
         point_valid_ff <= 1'b0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         res_x_ff       <= '0;
         res_y_ff       <= '0;
         click_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hid_ff         <= hid_in;
         point_valid_ff <= point_valid_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         res_x_ff       <= res_x_in;
         res_y_ff       <= res_y_in;
         click_ff       <= click_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      kind_ff  <= kind_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_report_kind = kind_ff;
   assign rsp_move_x      = mx_ff;
   assign rsp_move_y      = my_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ----- tb/touch_drag_to_mouse_steps_tb.sv -----
// Testbench for touch_drag_to_mouse_steps: directed and random touch gestures, checked
// beat by beat against an in-bench model of the step accumulator.
// Depends on tdms_pkg and the touch_drag_to_mouse_steps RTL.
module touch_drag_to_mouse_steps_tb;
   import tdms_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS   = COORD_BITS_DEF;
   localparam int COORD_MAX    = (1 << TOUCH_BITS) - 1;
   localparam int GAIN         = 2;
   localparam int RUN_MAX      = 52;
   localparam int SETTLE       = 8;
   localparam int TAIL_CYCLES  = 64;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 190;

   typedef struct packed {
      report_kind_type             kind;
      logic signed [STEP_BITS-1:0] move_x;
      logic signed [STEP_BITS-1:0] move_y;
      logic                        last_of_run;
   } mouse_report_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_wr_en = 1'b0;
   logic                        csr_wr_data = 1'b0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_action = ACT_PRESS;
   logic [TOUCH_BITS-1:0]       req_touch_x = '0;
   logic [TOUCH_BITS-1:0]       req_touch_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_report_kind;
   logic signed [STEP_BITS-1:0] rsp_move_x;
   logic signed [STEP_BITS-1:0] rsp_move_y;
   logic                        rsp_last_of_run;

   // model state
   logic                  hid_on = 1'b1;
   logic                  have_point = 1'b0;
   int                    last_x = 0;
   int                    last_y = 0;
   int                    acc_x = 0;
   int                    acc_y = 0;

   mouse_report_type expected_reports[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   logic             calm = 1'b0;
   logic             hold_request = 1'b0;

   touch_drag_to_mouse_steps #(.COORD_BITS(COORD_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_report_kind (rsp_report_kind),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, expected_reports.size());
         $display("touch_drag_to_mouse_steps_tb failed");
         $finish;
      end
   end

   function automatic int clamp_step(input int v);
      if (v > STEP_MAX) return STEP_MAX;
      if (v < -STEP_MAX) return -STEP_MAX;
      return v;
   endfunction

   function automatic logic past_thresh(input int v);
      return (v >= THRESH) || (v <= -THRESH);
   endfunction

   function automatic void predict_reports(input action_type act,
                                           input logic [TOUCH_BITS-1:0] tx,
                                           input logic [TOUCH_BITS-1:0] ty);
      int               nx;
      int               ny;
      int               sx;
      int               sy;
      int               n;
      mouse_report_type r;
      if (!hid_on) return;
      nx = int'(tx) & ((1 << COORD_BITS) - 1);
      ny = int'(ty) & ((1 << COORD_BITS) - 1);
      case (act)
         ACT_PRESS: begin
            have_point = 1'b1;
            last_x = nx;
            last_y = ny;
            acc_x = 0;
            acc_y = 0;
         end
         ACT_DRAG: begin
            if (have_point) begin
               acc_x += GAIN * (nx - last_x);
               acc_y += GAIN * (ny - last_y);
               n = 0;
               while ((past_thresh(acc_x) || past_thresh(acc_y)) && n < RUN_MAX) begin
                  sx = clamp_step(acc_x);
                  sy = clamp_step(acc_y);
                  acc_x -= sx;
                  acc_y -= sy;
                  n++;
                  r.kind = KIND_MOVE;
                  r.move_x = STEP_BITS'(sx);
                  r.move_y = STEP_BITS'(sy);
                  r.last_of_run = !((past_thresh(acc_x) || past_thresh(acc_y)) &&
                                    n < RUN_MAX);
                  expected_reports.push_back(r);
               end
            end
            have_point = 1'b1;
            last_x = nx;
            last_y = ny;
         end
         ACT_RELEASE: begin
            have_point = 1'b0;
            last_x = 0;
            last_y = 0;
            acc_x = 0;
            acc_y = 0;
         end
         default: begin
            r.kind = KIND_CLICK;
            r.move_x = '0;
            r.move_y = '0;
            r.last_of_run = 1'b1;
            expected_reports.push_back(r);
         end
      endcase
   endfunction

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0d] %s", cycle_count, what);
   endtask

   // result checker
   always @(posedge clock) begin
      mouse_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            log_mismatch($sformatf("unexpected beat: kind %0d x %0d y %0d last %0d",
                                   rsp_report_kind, rsp_move_x, rsp_move_y,
                                   rsp_last_of_run));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_report_kind !== want.kind || rsp_move_x !== want.move_x ||
                rsp_move_y !== want.move_y || rsp_last_of_run !== want.last_of_run)
               log_mismatch($sformatf(
                  "exp kind %0d x %0d y %0d last %0d, got kind %0d x %0d y %0d last %0d",
                  want.kind, $signed(want.move_x), $signed(want.move_y), want.last_of_run,
                  rsp_report_kind, rsp_move_x, rsp_move_y, rsp_last_of_run));
         end
      end
   end

   // receiver: short random stalls, one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_touch(input action_type act, input logic [TOUCH_BITS-1:0] tx,
                             input logic [TOUCH_BITS-1:0] ty);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_touch_x <= tx;
      req_touch_y <= ty;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_reports(act, tx, ty);
   endtask

   // sender pauses until every expected beat is out and the block has settled
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_hid_mode(input logic on);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      hid_on = on;
   endtask

   function automatic logic [TOUCH_BITS-1:0] rand_coord();
      return TOUCH_BITS'($urandom);
   endfunction

   function automatic logic [TOUCH_BITS-1:0] nudge(input logic [TOUCH_BITS-1:0] p,
                                                   input int span);
      int v;
      v = int'(p) - span + int'($urandom_range(0, 2 * span));
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return TOUCH_BITS'(v);
   endfunction

   task automatic test_drag_before_press();
      send_touch(ACT_DRAG, 9'd300, 9'd200);
      send_touch(ACT_DRAG, 9'd305, 9'd200);
      send_touch(ACT_RELEASE, 9'd305, 9'd200);
      send_touch(ACT_DRAG, 9'd10, 9'd490);
      send_touch(ACT_DRAG, 9'd10, 9'd480);
   endtask

   task automatic test_extremes();
      send_touch(ACT_PRESS, 9'd0, 9'd0);
      send_touch(ACT_DRAG, 9'd511, 9'd511);
      send_touch(ACT_DRAG, 9'd0, 9'd0);
      send_touch(ACT_DRAG, 9'd511, 9'd0);
      send_touch(ACT_DRAG, 9'd0, 9'd511);
      send_touch(ACT_PRESS, 9'd511, 9'd511);
      send_touch(ACT_DRAG, 9'd511, 9'd511);
      send_touch(ACT_RELEASE, 9'd511, 9'd511);
   endtask

   task automatic test_thresholds();
      send_touch(ACT_PRESS, 9'd100, 9'd100);
      send_touch(ACT_DRAG, 9'd104, 9'd100);
      send_touch(ACT_DRAG, 9'd105, 9'd100);
      send_touch(ACT_DRAG, 9'd105, 9'd95);
      send_touch(ACT_DRAG, 9'd109, 9'd98);
      send_touch(ACT_RELEASE, 9'd0, 9'd0);
   endtask

   task automatic test_clicks();
      send_touch(ACT_CLICK, 9'd0, 9'd0);
      send_touch(ACT_CLICK, 9'd511, 9'd511);
      send_touch(ACT_PRESS, 9'd200, 9'd200);
      send_touch(ACT_CLICK, 9'd1, 9'd2);
      send_touch(ACT_DRAG, 9'd220, 9'd180);
      send_touch(ACT_RELEASE, 9'd0, 9'd0);
   endtask

   // events with HID off must leave the stored point and residuals alone
   task automatic test_hid_off();
      send_touch(ACT_PRESS, 9'd50, 9'd50);
      send_touch(ACT_DRAG, 9'd54, 9'd47);
      write_hid_mode(1'b0);
      send_touch(ACT_PRESS, 9'd0, 9'd0);
      send_touch(ACT_DRAG, 9'd511, 9'd511);
      send_touch(ACT_RELEASE, 9'd511, 9'd0);
      send_touch(ACT_CLICK, 9'd0, 9'd511);
      write_hid_mode(1'b1);
      send_touch(ACT_DRAG, 9'd55, 9'd46);
      send_touch(ACT_RELEASE, 9'd0, 9'd0);
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      send_touch(ACT_PRESS, 9'd0, 9'd511);
      send_touch(ACT_DRAG, 9'd511, 9'd0);
      send_touch(ACT_DRAG, 9'd0, 9'd511);
      send_touch(ACT_CLICK, 9'd0, 9'd0);
      send_touch(ACT_DRAG, 9'd511, 9'd511);
      wait_idle();
   endtask

   task automatic test_random_gestures(input int goal);
      int                    done;
      int                    pick;
      int                    steps;
      int                    i;
      logic [TOUCH_BITS-1:0] cx;
      logic [TOUCH_BITS-1:0] cy;
      done = 0;
      while (done < goal) begin
         if (done >= goal - 40) calm = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            cx = rand_coord();
            cy = rand_coord();
            send_touch(ACT_PRESS, cx, cy);
            steps = $urandom_range(1, 8);
            for (i = 0; i < steps; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  cx = rand_coord();
                  cy = rand_coord();
               end else begin
                  cx = nudge(cx, 12);
                  cy = nudge(cy, 12);
               end
               send_touch(ACT_DRAG, cx, cy);
            end
            done += steps + 1;
            if ($urandom_range(0, 3) != 0) begin
               send_touch(ACT_RELEASE, rand_coord(), rand_coord());
               done++;
            end
         end else if (pick < 14) begin
            send_touch(ACT_CLICK, rand_coord(), rand_coord());
            done++;
         end else if (pick < 16) begin
            send_touch(ACT_RELEASE, rand_coord(), rand_coord());
            cx = rand_coord();
            cy = rand_coord();
            send_touch(ACT_DRAG, cx, cy);
            send_touch(ACT_DRAG, nudge(cx, 20), nudge(cy, 20));
            done += 3;
         end else if (pick < 18) begin
            steps = $urandom_range(1, 3);
            for (i = 0; i < steps; i++)
               send_touch(action_type'($urandom_range(0, 3)), rand_coord(), rand_coord());
            done += steps;
         end else begin
            write_hid_mode(1'b0);
            steps = $urandom_range(1, 3);
            for (i = 0; i < steps; i++)
               send_touch(action_type'($urandom_range(0, 3)), rand_coord(), rand_coord());
            done += steps;
            write_hid_mode(1'b1);
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      write_hid_mode(1'b1);
      test_drag_before_press();
      test_extremes();
      test_thresholds();
      test_clicks();
      test_hid_off();
      test_backpressure();
      test_random_gestures(RANDOM_ITEMS);
      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("touch_drag_to_mouse_steps_tb passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("touch_drag_to_mouse_steps_tb failed");
      end
      $finish;
   end

endmodule
